// File: rtl/assert_macros.svh
// Assertion macros used by the RTL of the divider's top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

// File: rtl/fdiv_pkg.sv
// Types and constants of the single-precision divider.
package fdiv_pkg;
  localparam int unsigned SigW = 24;
  localparam int unsigned NumW = 48;
  localparam int unsigned ExpW = 11;
  localparam int unsigned CntW = 6;
  localparam logic [7:0] ExpMax = 8'hFF;
  localparam logic [ExpW-1:0] ExpBias = 11'd127;
  localparam logic [CntW-1:0] DivLast = 6'd47;

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StNorm,
    StDone
  } state_e;
endpackage

// File: rtl/fdiv_unit.sv
// Restoring divider step: one compare and conditional subtract per cycle.
module fdiv_unit (
  input  logic [fdiv_pkg::SigW-1:0] rem_i,
  input  logic                      bit_i,
  input  logic [fdiv_pkg::SigW-1:0] div_i,
  output logic [fdiv_pkg::SigW-1:0] rem_o,
  output logic                      q_o
);
  logic [fdiv_pkg::SigW:0] trial;
  logic [fdiv_pkg::SigW:0] diff;

  assign trial = {rem_i, bit_i};
  assign diff  = trial - {1'b0, div_i};
  assign q_o   = (trial >= {1'b0, div_i});
  assign rem_o = q_o ? diff[fdiv_pkg::SigW-1:0] : trial[fdiv_pkg::SigW-1:0];
endmodule

// File: rtl/float32_divider_top.sv
// Top level of the iterative single-precision divider.
// A beat is accepted in the idle state, then the single restoring
// compare-and-subtract unit forms 48 quotient bits (one per step), then
// one-bit normalization shifts run, and the result is then offered on the
// output; zero operands go from the idle state straight to the output state.
// The block takes no new beat until the result has been taken.
`include "assert_macros.svh"
module float32_divider_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic [31:0] quotient_o,
  output logic        out_valid_o,
  input  logic        out_ready_i
);
  fdiv_pkg::state_e state_q, state_d;
  logic [fdiv_pkg::NumW-1:0] num_q, num_d;
  logic [fdiv_pkg::SigW-1:0] rem_q, rem_d;
  logic [fdiv_pkg::SigW-1:0] div_q, div_d;
  logic signed [fdiv_pkg::ExpW-1:0] exp_q, exp_d;
  logic [fdiv_pkg::CntW-1:0] cnt_q, cnt_d;
  logic sign_q, sign_d;
  logic [31:0] quot_q, quot_d;

  logic [7:0] exp_a, exp_b;
  logic a_zero, b_zero, special, norm_done;
  logic [fdiv_pkg::SigW-1:0] sig_a, sig_b, rem_next;
  logic [fdiv_pkg::ExpW-1:0] ea, eb;
  logic q_bit;

  assign exp_a  = dividend_i[30:23];
  assign exp_b  = divisor_i[30:23];
  assign a_zero = (dividend_i[30:0] == 31'd0);
  assign b_zero = (divisor_i[30:0] == 31'd0);
  assign special = a_zero || b_zero;
  assign sig_a = {(exp_a != 8'd0), dividend_i[22:0]};
  assign sig_b = {(exp_b != 8'd0), divisor_i[22:0]};
  assign ea = (exp_a == 8'd0) ? 11'd1 : {3'd0, exp_a};
  assign eb = (exp_b == 8'd0) ? 11'd1 : {3'd0, exp_b};
  assign norm_done = (num_q[47:24] == 24'd0) && num_q[23];

  fdiv_unit u_unit (
    .rem_i (rem_q),
    .bit_i (num_q[fdiv_pkg::NumW-1]),
    .div_i (div_q),
    .rem_o (rem_next),
    .q_o   (q_bit)
  );

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    div_d  = div_q;
    exp_d  = exp_q;
    cnt_d  = cnt_q;
    sign_d = sign_q;
    quot_d = quot_q;
    case (state_q)
      fdiv_pkg::StIdle: begin
        if (in_valid_i) begin
          sign_d = dividend_i[31] ^ divisor_i[31];
          if (a_zero && b_zero) begin
            quot_d = {1'b0, fdiv_pkg::ExpMax, 23'd1};
          end else if (a_zero) begin
            quot_d = {dividend_i[31] ^ divisor_i[31], 31'd0};
          end else if (b_zero) begin
            quot_d = {dividend_i[31] ^ divisor_i[31], fdiv_pkg::ExpMax, 23'd0};
          end
          num_d = {sig_a, 24'd0};
          rem_d = '0;
          div_d = sig_b;
          exp_d = $signed(ea - eb + fdiv_pkg::ExpBias);
          cnt_d = fdiv_pkg::DivLast;
        end
      end
      fdiv_pkg::StDiv: begin
        num_d = {num_q[fdiv_pkg::NumW-2:0], q_bit};
        rem_d = rem_next;
        cnt_d = cnt_q - 6'd1;
      end
      fdiv_pkg::StNorm: begin
        if (num_q[47:24] != 24'd0) begin
          num_d = {1'b0, num_q[fdiv_pkg::NumW-1:1]};
          exp_d = exp_q + 11'sd1;
        end else if (!num_q[23]) begin
          num_d = {num_q[fdiv_pkg::NumW-2:0], 1'b0};
          exp_d = exp_q - 11'sd1;
        end else if (exp_q >= 11'sd255) begin
          quot_d = {sign_q, fdiv_pkg::ExpMax, 23'd0};
        end else if (exp_q <= 11'sd0) begin
          quot_d = {sign_q, 31'd0};
        end else begin
          quot_d = {sign_q, exp_q[7:0], num_q[22:0]};
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      fdiv_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = special ? fdiv_pkg::StDone : fdiv_pkg::StDiv;
        end
      end
      fdiv_pkg::StDiv: begin
        if (cnt_q == 6'd0) begin
          state_d = fdiv_pkg::StNorm;
        end
      end
      fdiv_pkg::StNorm: begin
        if (norm_done) begin
          state_d = fdiv_pkg::StDone;
        end
      end
      fdiv_pkg::StDone: begin
        if (out_ready_i) begin
          state_d = fdiv_pkg::StIdle;
        end
      end
      default: state_d = fdiv_pkg::StIdle;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      fdiv_pkg::StIdle: in_ready_o = 1'b1;
      fdiv_pkg::StDone: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign quotient_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fdiv_pkg::StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
    exp_q  <= exp_d;
    sign_q <= sign_d;
    quot_q <= quot_d;
  end

  `ASSERT_IMPLIES(a_ready_excl, clk_i, rst_ni, in_ready_o, !out_valid_o)
  `ASSERT_IMPLIES(a_rem_below, clk_i, rst_ni, state_q == fdiv_pkg::StDiv, rem_q < div_q)
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(quotient_o))
  `ASSERT_NEXT(a_div_to_norm, clk_i, rst_ni, state_q == fdiv_pkg::StDiv && cnt_q == 6'd0, state_q == fdiv_pkg::StNorm)
endmodule

// File: tb/sv/tb_float32_divider_top.sv
// Testbench of the single-precision divider: random and corner operands, checked against a predictor.
module tb_float32_divider_top;

  logic        clk_i;
  logic        rst_ni;
  logic [31:0] dividend_i;
  logic [31:0] divisor_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] quotient_o;
  logic        out_valid_o;
  logic        out_ready_i;

  localparam logic [31:0] ZeroByZero = 32'h7F80_0001;
  localparam int unsigned NumRandom = 400;

  float32_divider_top u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .dividend_i(dividend_i),
    .divisor_i(divisor_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .quotient_o(quotient_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i)
  );

  logic [63:0] pending_q[$];
  logic [31:0] quotients_q[$];
  int          n_errors;
  int          n_sent;
  int          n_checked;
  bit          stim_done;
  int          in_gap;
  int          out_gap;
  int          hold_cycles;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [31:0] fp_quotient(logic [31:0] a, logic [31:0] b);
    logic        sq;
    logic [7:0]  ea;
    logic [7:0]  eb;
    logic [22:0] fa;
    logic [22:0] fb;
    logic [63:0] sa;
    logic [63:0] sb;
    logic [63:0] q;
    int          eq;
    sq = a[31] ^ b[31];
    ea = a[30:23];
    eb = b[30:23];
    fa = a[22:0];
    fb = b[22:0];
    if (ea == 0 && fa == 0 && eb == 0 && fb == 0) return ZeroByZero;
    if (ea == 0 && fa == 0) return {sq, 31'd0};
    if (eb == 0 && fb == 0) return {sq, 8'hFF, 23'd0};
    sa = (ea == 0) ? {41'd0, fa} : {40'd0, 1'b1, fa};
    sb = (eb == 0) ? {41'd0, fb} : {40'd0, 1'b1, fb};
    eq = ((ea == 0) ? 1 : int'(ea)) - ((eb == 0) ? 1 : int'(eb)) + 127;
    q = (sa << 24) / sb;
    while (q != 0 && q < 64'h80_0000) begin
      q = q << 1;
      eq--;
    end
    while (q >= 64'h100_0000) begin
      q = q >> 1;
      eq++;
    end
    if (eq >= 255) return {sq, 8'hFF, 23'd0};
    if (eq <= 0) return {sq, 31'd0};
    return {sq, eq[7:0], q[22:0]};
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 5) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 7))
      0: w[30:23] = 8'h00;
      1: w[30:23] = 8'hFF;
      2: w[30:0] = 31'd0;
      3: w[30:23] = $urandom_range(0, 1) ? 8'd1 : 8'd254;
      default: w[30:23] = 8'($urandom_range(90, 165));
    endcase
    return w;
  endfunction

  initial begin
    logic [31:0] corners[12];
    corners = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
                32'h0000_0001, 32'h007F_FFFF, 32'h0080_0000, 32'h7F7F_FFFF,
                32'h7F80_0000, 32'hFFFF_FFFF, 32'h4000_0000, 32'h3F7F_FFFF};
    foreach (corners[i]) pending_q.push_back({corners[i], corners[(i * 5 + 3) % 12]});
    pending_q.push_back({32'h0000_0000, 32'h0000_0000});
    pending_q.push_back({32'h8000_0000, 32'h3F80_0000});
    pending_q.push_back({32'hC000_0000, 32'h8000_0000});
    pending_q.push_back({32'h7F7F_FFFF, 32'h0000_0001});
    pending_q.push_back({32'h0000_0001, 32'h7F7F_FFFF});
    pending_q.push_back({32'h0080_0000, 32'h4000_0000});
    pending_q.push_back({32'h0000_0001, 32'h0080_0000});
    pending_q.push_back({32'hFFFF_FFFF, 32'hFFFF_FFFF});
    pending_q.push_back({32'h3FFF_FFFF, 32'h3F80_0001});
    for (int i = 0; i < NumRandom; i++) pending_q.push_back({rand_word(), rand_word()});
    stim_done = 1'b1;
  end

  initial begin
    n_errors = 0;
    n_sent = 0;
    n_checked = 0;
    in_gap = 0;
    out_gap = 0;
    hold_cycles = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    dividend_i = '0;
    divisor_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        quotients_q.push_back(fp_quotient(dividend_i, divisor_i));
        n_sent <= n_sent + 1;
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (in_gap > 0) begin
          in_valid_i <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (pending_q.size() > 0) begin
          {dividend_i, divisor_i} <= pending_q.pop_front();
          in_valid_i <= 1'b1;
          in_gap <= (n_sent > 40 && n_sent < 100) ? 0 : pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (quotients_q.size() == 0) begin
          $error("unexpected beat: quotient actual %h", quotient_o);
          n_errors++;
        end else begin
          want = quotients_q.pop_front();
          if (quotient_o !== want) begin
            $error("quotient: expected %h actual %h", want, quotient_o);
            n_errors++;
          end
        end
        n_checked <= n_checked + 1;
      end
      if (n_checked == 60 && hold_cycles == 0) begin
        hold_cycles <= 400;
        out_ready_i <= 1'b0;
      end else if (hold_cycles > 1) begin
        hold_cycles <= hold_cycles - 1;
        out_ready_i <= 1'b0;
      end else if (out_gap > 0) begin
        if (hold_cycles == 1) hold_cycles <= -1;
        out_gap <= out_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        if (hold_cycles == 1) hold_cycles <= -1;
        out_ready_i <= 1'b1;
        out_gap <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
    end
  end

  initial begin
    wait (stim_done);
    @(posedge clk_i);
    wait (pending_q.size() == 0 && !in_valid_i && quotients_q.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d divisions, checked %0d quotients, with zeros, subnormals,", n_sent,
             n_checked);
    $display("infinities, NaNs, overflow, underflow and a long output stall.");
    if (n_errors == 0 && quotients_q.size() == 0) begin
      $display("tb_float32_divider_top: clean");
    end else begin
      $display("tb_float32_divider_top: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_float32_divider_top: errors");
    $finish;
  end

endmodule
